/* sv/page_slot_sort_merge_core_defines.svh */
// assertion macros for the sort and merge block
`ifndef PAGE_SLOT_SORT_MERGE_CORE_DEFINES_SVH
`define PAGE_SLOT_SORT_MERGE_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PSSM_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define PSSM_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/pssm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pssm_pkg;
    localparam int DefCapacity = 1024;
    localparam int KeyW = 16;
    localparam int CmdW = 3;
    localparam int CfgIdxW = 1;

    localparam logic [CmdW-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CmdW-1:0] CMD_LOAD_STR = 3'd1;
    localparam logic [CmdW-1:0] CMD_LOAD_HOLE = 3'd2;
    localparam logic [CmdW-1:0] CMD_SORT = 3'd3;
    localparam logic [CmdW-1:0] CMD_READ = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_SIT_BASE = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_EMPTY_MARKER = 1'd1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_CLASH = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic            kind;
        logic [KeyW-1:0] offset;
        logic [KeyW-1:0] value;
    } entry_t;
endpackage
`default_nettype wire

/* sv/page_slot_sort_merge_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// page slot sort and merge core
// command channel: start with command, slot_offset and slot_key is taken
// when busy is low. clear and load give no result and leave busy low.
// sort runs an insertion sort over the stored entries through one memory
// port pair and one key comparator, then a clash scan over the sorted
// entries, then a strobe with status.
// read next does a memory read, then the entry is driven for one
// cycle with out_valid and is_last marked on the final entry.
// reads before a sort or past the end give nothing.
// configuration: cfg_we, cfg_index, cfg_data; the user writes these only
// when idle (not enforced). sit_base is index 0, empty_marker index 1.
// results show for exactly one cycle; the receiver cannot stall.
// reset clears counters, flags, state and config registers; the entry
// memory holds whatever it had and only written entries are ever read.
// a load while full is dropped and, if its key is valid, sets overflow.
module page_slot_sort_merge_core
    import pssm_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CmdW-1:0]     command,
    input  wire logic [KeyW-1:0]     slot_offset,
    input  wire logic [KeyW-1:0]     slot_key,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [KeyW-1:0]     cfg_data,
    output logic                     out_valid,
    output logic                     entry_kind,
    output logic [KeyW-1:0]          entry_offset,
    output logic [KeyW-1:0]          entry_value,
    output logic                     is_last,
    output logic [1:0]               status
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_OUTER  = 9'b000000010,
        ST_RDPREV = 9'b000000100,
        ST_CMP    = 9'b000001000,
        ST_PLACE  = 9'b000010000,
        ST_SCAN   = 9'b000100000,
        ST_SCMP   = 9'b001000000,
        ST_RD     = 9'b010000000,
        ST_RDOUT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    entry_t mem [CAPACITY];
    entry_t rdata_reg;
    entry_t cur_reg, cur_next;
    entry_t prev_reg, prev_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic ovf_reg, ovf_next, sorted_reg, sorted_next, clash_reg, clash_next;
    logic [KeyW-1:0] sit_reg, empty_reg;
    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata;
    logic accept;
    logic [KeyW:0] limit;
    logic ov_next;
    logic [1:0] st_next_val;
    logic kind_o_next, last_o_next;
    logic [KeyW-1:0] off_o_next, val_o_next;
    logic ov_reg;
    logic kind_o_reg, last_o_reg;
    logic [KeyW-1:0] off_o_reg, val_o_reg;
    logic [1:0] st_o_reg;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);
    assign limit = {1'b0, sit_reg} + (KeyW+1)'(2);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sit_reg <= '0;
            empty_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIT_BASE:     sit_reg <= cfg_data;
                REG_EMPTY_MARKER: empty_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        count_next = count_reg;
        rptr_next = rptr_reg;
        i_next = i_reg;
        j_next = j_reg;
        ovf_next = ovf_reg;
        sorted_next = sorted_reg;
        clash_next = clash_reg;
        we = 1'b0;
        waddr = '0;
        wdata = cur_reg;
        raddr = '0;
        ov_next = 1'b0;
        kind_o_next = 1'b0;
        off_o_next = '0;
        val_o_next = '0;
        last_o_next = 1'b0;
        st_next_val = ovf_reg ? STATUS_OVERFLOW : (clash_reg ? STATUS_CLASH : STATUS_OK);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            rptr_next = '0;
                            ovf_next = 1'b0;
                            sorted_next = 1'b0;
                            clash_next = 1'b0;
                        end
                        CMD_LOAD_STR, CMD_LOAD_HOLE:
                        begin
                            if (command == CMD_LOAD_HOLE || (slot_key != empty_reg
                                && {1'b0, slot_key} < limit))
                            begin
                                if (count_reg < CAP_C)
                                begin
                                    we = 1'b1;
                                    waddr = count_reg[AW-1:0];
                                    wdata.kind = (command == CMD_LOAD_HOLE);
                                    wdata.offset = slot_offset;
                                    wdata.value = slot_key;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                sorted_next = 1'b0;
                                rptr_next = '0;
                            end
                        end
                        CMD_SORT:
                        begin
                            i_next = CW'(1);
                            state_next = ST_OUTER;
                        end
                        CMD_READ:
                        begin
                            if (sorted_reg && rptr_reg < count_reg)
                            begin
                                raddr = rptr_reg[AW-1:0];
                                state_next = ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_OUTER:
            begin
                if (i_reg < count_reg)
                begin
                    raddr = i_reg[AW-1:0];
                    j_next = i_reg;
                    state_next = ST_RDPREV;
                end
                else
                begin
                    clash_next = 1'b0;
                    i_next = CW'(1);
                    raddr = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_RDPREV:
            begin
                cur_next = rdata_reg;
                raddr = AW'(j_reg - CW'(1));
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if ({rdata_reg.value, rdata_reg.kind} > {cur_reg.value, cur_reg.kind})
                begin
                    we = 1'b1;
                    waddr = j_reg[AW-1:0];
                    wdata = rdata_reg;
                    j_next = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        raddr = AW'(j_reg - CW'(2));
                        state_next = ST_CMP;
                    end
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                we = 1'b1;
                waddr = j_reg[AW-1:0];
                wdata = cur_reg;
                i_next = i_reg + CW'(1);
                state_next = ST_OUTER;
            end
            ST_SCAN:
            begin
                prev_next = rdata_reg;
                if (i_reg < count_reg)
                begin
                    raddr = i_reg[AW-1:0];
                    state_next = ST_SCMP;
                end
                else
                begin
                    sorted_next = 1'b1;
                    rptr_next = '0;
                    ov_next = 1'b1;
                    st_next_val = ovf_reg ? STATUS_OVERFLOW
                        : (clash_reg ? STATUS_CLASH : STATUS_OK);
                    state_next = ST_IDLE;
                end
            end
            ST_SCMP:
            begin
                if (rdata_reg.value == prev_reg.value && rdata_reg.kind != prev_reg.kind)
                begin
                    clash_next = 1'b1;
                end
                prev_next = rdata_reg;
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) < count_reg)
                begin
                    raddr = AW'(i_reg + CW'(1));
                    state_next = ST_SCMP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_RD:
            begin
                raddr = rptr_reg[AW-1:0];
                state_next = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                ov_next = 1'b1;
                kind_o_next = rdata_reg.kind;
                off_o_next = rdata_reg.offset;
                val_o_next = rdata_reg.value;
                last_o_next = (rptr_reg + CW'(1) == count_reg);
                rptr_next = rptr_reg + CW'(1);
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rptr_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            ovf_reg <= 1'b0;
            sorted_reg <= 1'b0;
            clash_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rptr_reg <= rptr_next;
            i_reg <= i_next;
            j_reg <= j_next;
            ovf_reg <= ovf_next;
            sorted_reg <= sorted_next;
            clash_reg <= clash_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        kind_o_reg <= kind_o_next;
        off_o_reg <= off_o_next;
        val_o_reg <= val_o_next;
        last_o_reg <= last_o_next;
        st_o_reg <= st_next_val;
    end

    assign out_valid = ov_reg;
    assign entry_kind = kind_o_reg;
    assign entry_offset = off_o_reg;
    assign entry_value = val_o_reg;
    assign is_last = last_o_reg;
    assign status = st_o_reg;
endmodule
`default_nettype wire

/* sv/pssm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "page_slot_sort_merge_core_defines.svh"
module pssm_checker
    import pssm_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic [CmdW-1:0] command,
    input wire logic            out_valid,
    input wire logic [1:0]      status
);
    `PSSM_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, out_valid, !out_valid)
    `PSSM_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status != 2'd3)
    `PSSM_ASSERT_NEXT(a_sort_busy, clk, rst_n, start && !busy && command == CMD_SORT, busy)
    `PSSM_ASSERT_NEXT(a_clear_quiet, clk, rst_n, start && !busy && command == CMD_CLEAR,
        !out_valid && !busy)
endmodule

bind page_slot_sort_merge_core pssm_checker u_pssm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
    .out_valid(out_valid), .status(status)
);
`default_nettype wire

/* tb/page_slot_sort_merge_core_tb.sv */
`timescale 1ns / 1ps
module page_slot_sort_merge_core_tb;
    import pssm_pkg::*;

    localparam int Cap = DefCapacity;
    localparam int IdleLimit = 4 * (Cap * Cap / 2 + 5 * Cap + 16);

    typedef struct packed {
        logic            kind;
        logic [KeyW-1:0] offset;
        logic [KeyW-1:0] value;
        logic            last;
        logic [1:0]      status;
    } slot_out_t;

    typedef struct packed {
        logic [CmdW-1:0] cmd;
        logic [KeyW-1:0] offset;
        logic [KeyW-1:0] value;
        logic            typed;
        slot_out_t       res;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CmdW-1:0]     command;
    logic [KeyW-1:0]     slot_offset;
    logic [KeyW-1:0]     slot_key;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [KeyW-1:0]     cfg_data;
    logic                out_valid;
    logic                entry_kind;
    logic [KeyW-1:0]     entry_offset;
    logic [KeyW-1:0]     entry_value;
    logic                is_last;
    logic [1:0]          status;

    page_slot_sort_merge_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .slot_offset(slot_offset), .slot_key(slot_key),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .entry_kind(entry_kind), .entry_offset(entry_offset),
        .entry_value(entry_value), .is_last(is_last), .status(status)
    );

    // predictor state
    entry_t      slot_mem [Cap];
    int          slot_cnt;
    int          rd_ptr;
    bit          ovf_flag;
    bit          sorted;
    bit          clash;
    logic [15:0] sit_base_r;
    logic [15:0] empty_mark_r;

    slot_out_t   pend_q[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_sorts;
    int          n_clash;
    int          n_ovf;
    int          idle_cnt;
    int          gap_pct;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic void sort_slots();
        entry_t cur;
        int     j;
        for (int i = 1; i < slot_cnt; i++) begin
            cur = slot_mem[i];
            j = i;
            while (j > 0 && {slot_mem[j-1].value, slot_mem[j-1].kind} > {cur.value, cur.kind})
            begin
                slot_mem[j] = slot_mem[j-1];
                j--;
            end
            slot_mem[j] = cur;
        end
        clash = 1'b0;
        for (int i = 1; i < slot_cnt; i++)
            if (slot_mem[i-1].value == slot_mem[i].value && slot_mem[i-1].kind != slot_mem[i].kind)
                clash = 1'b1;
        sorted = 1'b1;
        rd_ptr = 0;
    endfunction

    function automatic void put_slot(input logic kind, input logic [15:0] off,
                                     input logic [15:0] val);
        if (slot_cnt < Cap) begin
            slot_mem[slot_cnt] = '{kind: kind, offset: off, value: val};
            slot_cnt++;
        end else begin
            ovf_flag = 1'b1;
        end
        sorted = 1'b0;
        rd_ptr = 0;
    endfunction

    function automatic logic [1:0] cur_status();
        if (ovf_flag)
            return STATUS_OVERFLOW;
        return clash ? STATUS_CLASH : STATUS_OK;
    endfunction

    function automatic bit predict_slot(input logic [CmdW-1:0] cmd, input logic [15:0] off,
                                        input logic [15:0] val, output slot_out_t res);
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                slot_cnt = 0;
                rd_ptr = 0;
                ovf_flag = 1'b0;
                sorted = 1'b0;
                clash = 1'b0;
            end
            CMD_LOAD_STR: begin
                if (!(val == empty_mark_r || {1'b0, val} >= {1'b0, sit_base_r} + 17'd2))
                    put_slot(1'b0, off, val);
            end
            CMD_LOAD_HOLE: put_slot(1'b1, off, val);
            CMD_SORT: begin
                sort_slots();
                res.status = cur_status();
                n_sorts++;
                if (res.status == STATUS_CLASH)
                    n_clash++;
                if (res.status == STATUS_OVERFLOW)
                    n_ovf++;
                return 1'b1;
            end
            CMD_READ: begin
                if (!sorted || rd_ptr >= slot_cnt)
                    return 1'b0;
                res.kind = slot_mem[rd_ptr].kind;
                res.offset = slot_mem[rd_ptr].offset;
                res.value = slot_mem[rd_ptr].value;
                res.last = (rd_ptr + 1 == slot_cnt);
                res.status = cur_status();
                rd_ptr++;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // drive one command and hold it until the transfer happens
    task automatic send(input logic [CmdW-1:0] cmd, input logic [15:0] off,
                        input logic [15:0] val, input bit typed = 0,
                        input slot_out_t typed_res = '0);
        slot_out_t res;
        bit        has;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        slot_offset <= off;
        slot_key <= val;
        do
            @(posedge clk);
        while (busy);
        has = predict_slot(cmd, off, val, res);
        if (typed && has)
            res = typed_res;
        if (has)
            pend_q.push_back(res);
        n_items++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pend_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] base, input logic [15:0] mark);
        cfg_we <= 1'b1;
        cfg_index <= REG_SIT_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= REG_EMPTY_MARKER;
        cfg_data <= mark;
        @(posedge clk);
        cfg_we <= 1'b0;
        sit_base_r = base;
        empty_mark_r = mark;
        @(posedge clk);
    endtask

    function automatic logic [15:0] str_value();
        int top;
        top = (sit_base_r > 16'hfffd) ? 65535 : sit_base_r + 1;
        case ($urandom_range(7))
            0: return 16'($urandom);
            1: return empty_mark_r;
            default: return 16'($urandom_range(top));
        endcase
    endfunction

    // a well-formed batch: optional clear, loads, sort, read-out mixed with occasional random commands
    task automatic batch();
        int          k;
        int          narrow;
        logic [15:0] v;
        if ($urandom_range(2) == 0)
            send(CMD_CLEAR, 16'($urandom), 16'($urandom));
        k = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(12);
        narrow = $urandom_range(1);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(1)) begin
                v = narrow ? 16'($urandom_range(7)) : 16'($urandom);
                send(CMD_LOAD_HOLE, 16'($urandom), v);
            end else begin
                v = str_value();
                if (narrow && $urandom_range(1))
                    v = 16'($urandom_range(7));
                send(CMD_LOAD_STR, 16'($urandom), v);
            end
        end
        send(CMD_SORT, 16'($urandom), 16'($urandom));
        for (int i = 0; i < k + $urandom_range(2); i++) begin
            if ($urandom_range(11) == 0)
                send(CmdW'($urandom_range(7)), 16'($urandom), 16'($urandom));
            else
                send(CMD_READ, 16'($urandom), 16'($urandom));
        end
    endtask

    stim_row_t rows[] = '{
        '{CMD_READ,      16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_SORT,      16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 0, STATUS_OK}},
        '{CMD_READ,      16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_LOAD_STR,  16'hffff, 16'h0001, 1'b0, '0},
        '{CMD_LOAD_STR,  16'h1111, 16'h0000, 1'b0, '0},
        '{CMD_LOAD_STR,  16'h2222, 16'h0002, 1'b0, '0},
        '{CMD_LOAD_HOLE, 16'h0000, 16'hffff, 1'b0, '0},
        '{CMD_LOAD_HOLE, 16'h1234, 16'h0001, 1'b0, '0},
        '{3'd5,          16'hffff, 16'hffff, 1'b0, '0},
        '{3'd6,          16'h0000, 16'h0000, 1'b0, '0},
        '{3'd7,          16'haaaa, 16'h5555, 1'b0, '0},
        '{CMD_SORT,      16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 0, STATUS_CLASH}},
        '{CMD_READ,      16'h0000, 16'h0000, 1'b1, '{0, 16'hffff, 1, 0, STATUS_CLASH}},
        '{CMD_READ,      16'h0000, 16'h0000, 1'b1, '{1, 16'h1234, 1, 0, STATUS_CLASH}},
        '{CMD_READ,      16'h0000, 16'h0000, 1'b1, '{1, 16'h0000, 16'hffff, 1, STATUS_CLASH}},
        '{CMD_READ,      16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_CLEAR,     16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_SORT,      16'h0000, 16'h0000, 1'b1, '{0, 0, 0, 0, STATUS_OK}}
    };

    // result check
    always @(posedge clk) begin
        slot_out_t want;
        if (rst_n && out_valid) begin
            n_results++;
            if (pend_q.size() == 0) begin
                report("unexpected result", entry_value, 0);
            end else begin
                want = pend_q.pop_front();
                if (entry_kind !== want.kind)
                    report("entry_kind", entry_kind, want.kind);
                if (entry_offset !== want.offset)
                    report("entry_offset", entry_offset, want.offset);
                if (entry_value !== want.value)
                    report("entry_value", entry_value, want.value);
                if (is_last !== want.last)
                    report("is_last", is_last, want.last);
                if (status !== want.status)
                    report("status", status, want.status);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || out_valid)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IdleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    logic [15:0] cfg_set [5][2] = '{
        '{16'hffff, 16'hffff}, '{16'hffff, 16'h0000}, '{16'h0064, 16'h0005},
        '{16'h0000, 16'h0001}, '{16'h0010, 16'h0003}
    };

    initial begin
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_sorts = 0;
        n_clash = 0;
        n_ovf = 0;
        idle_cnt = 0;
        gap_pct = 0;
        slot_cnt = 0;
        rd_ptr = 0;
        ovf_flag = 0;
        sorted = 0;
        clash = 0;
        sit_base_r = '0;
        empty_mark_r = '0;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        slot_offset = '0;
        slot_key = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].cmd, rows[i].offset, rows[i].value, rows[i].typed, rows[i].res);
        drain();

        // capacity exceeded: ascending keys keep the sort short
        set_regs(16'hffff, 16'h0000);
        for (int i = 0; i < Cap + 2; i++)
            send(CMD_LOAD_HOLE, 16'(i * 7), 16'(i));
        send(CMD_SORT, 0, 0);
        repeat (3) send(CMD_READ, 0, 0);
        send(CMD_CLEAR, 0, 0);
        drain();

        for (int p = 0; p < 10; p++) begin
            if (p < 5)
                set_regs(cfg_set[p][0], cfg_set[p][1]);
            else
                set_regs(16'($urandom), 16'($urandom));
            gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 52 : 25);
            repeat (3) batch();
            drain();
        end

        $display("covered %0d commands, %0d results, %0d sorts", n_items, n_results, n_sorts);
        $display("sorts with key clash %0d, with overflow %0d", n_clash, n_ovf);
        if (errors == 0 && pend_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
